/* sv/uart_reply_scanner_macros.svh */
// Assertion macros shared by the scanner modules.
// Each one samples on clk_i and is switched off while rst_ni is low.
`ifndef UART_REPLY_SCANNER_MACROS_SVH
`define UART_REPLY_SCANNER_MACROS_SVH

// Check a property that must hold at every clock edge outside reset.
`define URS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("scanner assertion failed");

// Check that a condition never becomes true outside reset.
`define URS_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("scanner forbidden condition seen");

`endif

/* sv/urs_pkg.sv */
`default_nettype none

package urs_pkg;

  // Characters that the tracker and the framer look for
  localparam logic [7:0] ChH = 8'h48;
  localparam logic [7:0] ChR = 8'h52;
  localparam logic [7:0] ChE = 8'h45;
  localparam logic [7:0] ChS = 8'h53;
  localparam logic [7:0] ChP = 8'h50;
  localparam logic [7:0] ChC = 8'h43;
  localparam logic [7:0] ChO = 8'h4F;
  localparam logic [7:0] ChN = 8'h4E;

  // Heart-rate tracker phases; the fourth code behaves as idle
  localparam logic [1:0] HrIdle  = 2'd0;
  localparam logic [1:0] HrGotH  = 2'd1;
  localparam logic [1:0] HrGotHR = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the incoming byte
    logic commit;  // apply the captured byte to the tracker and framer
  } cmd_t;

endpackage

`default_nettype wire

/* sv/urs_ctrl.sv */
`default_nettype none

module urs_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output urs_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StWork = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.load   = 1'b0;
    cmd_o.commit = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StWork;
        end
      end
      StWork: begin
        // hold the update until the previous result has gone
        if (out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`include "uart_reply_scanner_macros.svh"

  `URS_ASSERT(a_load_then_work, cmd_o.load |=> state_q == StWork)
  `URS_ASSERT(a_result_from_work, $rose(out_valid_q) |-> $past(state_q == StWork))
  `URS_NEVER(a_commit_over_held, cmd_o.commit && out_valid_q && out_stall_i)

endmodule

`default_nettype wire

/* sv/urs_datapath.sv */
`default_nettype none

module urs_datapath #(
  parameter int FRAME_BYTES = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire urs_pkg::cmd_t cmd_i,
  input  wire logic [7:0]    rx_byte_i,
  output logic [7:0]         heart_rate_o,
  output logic [15:0]        heart_rate_count_o,
  output logic               link_ok_o,
  output logic [15:0]        connect_count_o,
  output logic               frame_done_o
);

  localparam int FillW = $clog2(FRAME_BYTES);
  localparam logic [FillW-1:0] LastPos = FillW'(FRAME_BYTES - 1);

  logic [7:0]       byte_q;
  logic [1:0]       phase_q, phase_d;
  logic [7:0]       rate_q, rate_d;
  logic [15:0]      rate_cnt_q, rate_cnt_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic [7:0]       hist1_q, hist1_d, hist0_q, hist0_d;
  logic             zero_q, zero_d;
  logic             esp_q, esp_d, con_q, con_d;
  logic             link_q, link_d;
  logic [15:0]      con_cnt_q, con_cnt_d;
  logic             done_q, done_d;
  logic             opener, window_ok, esp_now, con_now;

  assign opener    = ((byte_q == urs_pkg::ChE) && !link_q) || (byte_q == urs_pkg::ChC);
  // a match only counts while no zero byte came before it in the frame
  assign window_ok = (fill_q >= FillW'(2)) && !zero_q;
  assign esp_now   = window_ok && hist1_q == urs_pkg::ChE && hist0_q == urs_pkg::ChS
                     && byte_q == urs_pkg::ChP;
  assign con_now   = window_ok && hist1_q == urs_pkg::ChC && hist0_q == urs_pkg::ChO
                     && byte_q == urs_pkg::ChN;

  always_comb begin
    phase_d    = urs_pkg::HrIdle;
    rate_d     = rate_q;
    rate_cnt_d = rate_cnt_q;
    case (phase_q)
      urs_pkg::HrGotH: begin
        if (byte_q == urs_pkg::ChR) begin
          phase_d = urs_pkg::HrGotHR;
        end
      end
      urs_pkg::HrGotHR: begin
        rate_d = byte_q;
        if (byte_q != 8'd0) begin
          rate_cnt_d = rate_cnt_q + 16'd1;
        end
      end
      default: begin
        if (byte_q == urs_pkg::ChH) begin
          phase_d = urs_pkg::HrGotH;
        end
      end
    endcase
  end

  always_comb begin
    fill_d    = fill_q;
    hist1_d   = hist1_q;
    hist0_d   = hist0_q;
    zero_d    = zero_q;
    esp_d     = esp_q;
    con_d     = con_q;
    link_d    = link_q;
    con_cnt_d = con_cnt_q;
    done_d    = 1'b0;
    if (fill_q == '0) begin
      if (opener) begin
        fill_d  = FillW'(1);
        hist0_d = byte_q;
        zero_d  = 1'b0;
        esp_d   = 1'b0;
        con_d   = 1'b0;
      end
    end else if (fill_q == LastPos) begin
      fill_d = '0;
      done_d = 1'b1;
      if (esp_q || esp_now) begin
        link_d = 1'b1;
      end
      if (con_q || con_now) begin
        con_cnt_d = con_cnt_q + 16'd1;
      end
    end else begin
      fill_d  = fill_q + FillW'(1);
      hist1_d = hist0_q;
      hist0_d = byte_q;
      zero_d  = zero_q || (byte_q == 8'd0);
      esp_d   = esp_q || esp_now;
      con_d   = con_q || con_now;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      byte_q <= rx_byte_i;
    end
    if (cmd_i.commit) begin
      hist1_q <= hist1_d;
      hist0_q <= hist0_d;
      zero_q  <= zero_d;
      esp_q   <= esp_d;
      con_q   <= con_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= urs_pkg::HrIdle;
      rate_q     <= '0;
      rate_cnt_q <= '0;
      fill_q     <= '0;
      link_q     <= 1'b0;
      con_cnt_q  <= '0;
      done_q     <= 1'b0;
    end else if (cmd_i.commit) begin
      phase_q    <= phase_d;
      rate_q     <= rate_d;
      rate_cnt_q <= rate_cnt_d;
      fill_q     <= fill_d;
      link_q     <= link_d;
      con_cnt_q  <= con_cnt_d;
      done_q     <= done_d;
    end
  end

  assign heart_rate_o       = rate_q;
  assign heart_rate_count_o = rate_cnt_q;
  assign link_ok_o          = link_q;
  assign connect_count_o    = con_cnt_q;
  assign frame_done_o       = done_q;

`include "uart_reply_scanner_macros.svh"

  `URS_NEVER(a_fill_in_range, fill_q > LastPos)
  `URS_ASSERT(a_link_sticky, link_q |=> link_q)
  `URS_ASSERT(a_done_closes, (cmd_i.commit && done_d) |=> (fill_q == '0))

endmodule

`default_nettype wire

/* sv/uart_reply_scanner.sv */
// Channel  | Handshake                   | Payload
// ---------+-----------------------------+--------------------------------------------
// input    | in_valid_i / in_stall_o     | rx_byte_i
// output   | out_valid_o / out_stall_i   | heart_rate_o, heart_rate_count_o, link_ok_o,
//          |                             | connect_count_o, frame_done_o
//
// Each byte is handled by the two-state controller: capture it,
// then apply it to the tracker and framer state.
// Hold the update while an earlier result sits on a stalled output; the next
// byte is captured while that result waits.
// Reset (rst_ni low, asynchronous) clears every control and result register.
// Search the frame window as bytes arrive, so a frame closes with its last byte.
`default_nettype none

module uart_reply_scanner #(
  parameter int FRAME_BYTES = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input transaction
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  // output transaction
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       heart_rate_o,
  output logic [15:0]      heart_rate_count_o,
  output logic             link_ok_o,
  output logic [15:0]      connect_count_o,
  output logic             frame_done_o
);

  // Commands from the sequencer: capture a byte, then apply it
  urs_pkg::cmd_t cmd;

  urs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // The state registers double as the result register: they only move on
  // an update, and an update is held back while a result waits on a stalled output.
  urs_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .rx_byte_i          (rx_byte_i),
    .heart_rate_o       (heart_rate_o),
    .heart_rate_count_o (heart_rate_count_o),
    .link_ok_o          (link_ok_o),
    .connect_count_o    (connect_count_o),
    .frame_done_o       (frame_done_o)
  );

endmodule

`default_nettype wire
